>>> rtl/fvt_pkg.sv
// Shared types and constants for the feature visibility test pipeline.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package fvt_pkg;

    // Image geometry and test limits
    localparam int IMAGE_WIDTH      = 640;
    localparam int IMAGE_HEIGHT     = 480;
    localparam int MAX_LENGTH_RATIO = 2;
    localparam int MAX_ANGLE_DEG    = 45;

    localparam int ONE_Q30 = 1073741824;

    // Upper edge of the image in Q16.16, before the margin is taken off
    localparam logic signed [33:0] U_LIMIT = 34'((IMAGE_WIDTH - 1) * 65536);
    localparam logic signed [33:0] V_LIMIT = 34'((IMAGE_HEIGHT - 1) * 65536);

    localparam logic [6:0] RATIO_SQ = 7'(MAX_LENGTH_RATIO * MAX_LENGTH_RATIO);

    // cos^2 of the angle limit in Q0.30: eleven-term Taylor series, truncating
    localparam logic [63:0] ANG_X  = (64'(MAX_ANGLE_DEG) * 64'd3373259426) / 64'd180;
    localparam logic [63:0] ANG_X2 = (ANG_X * ANG_X) >> 30;
    localparam logic [63:0] ANG_T1  = ((64'(ONE_Q30) * ANG_X2) >> 30) / 64'd2;
    localparam logic [63:0] ANG_T2  = ((ANG_T1 * ANG_X2) >> 30) / 64'd12;
    localparam logic [63:0] ANG_T3  = ((ANG_T2 * ANG_X2) >> 30) / 64'd30;
    localparam logic [63:0] ANG_T4  = ((ANG_T3 * ANG_X2) >> 30) / 64'd56;
    localparam logic [63:0] ANG_T5  = ((ANG_T4 * ANG_X2) >> 30) / 64'd90;
    localparam logic [63:0] ANG_T6  = ((ANG_T5 * ANG_X2) >> 30) / 64'd132;
    localparam logic [63:0] ANG_T7  = ((ANG_T6 * ANG_X2) >> 30) / 64'd182;
    localparam logic [63:0] ANG_T8  = ((ANG_T7 * ANG_X2) >> 30) / 64'd240;
    localparam logic [63:0] ANG_T9  = ((ANG_T8 * ANG_X2) >> 30) / 64'd306;
    localparam logic [63:0] ANG_T10 = ((ANG_T9 * ANG_X2) >> 30) / 64'd380;
    localparam longint COS_C = longint'(ONE_Q30)
        - longint'(ANG_T1) + longint'(ANG_T2) - longint'(ANG_T3) + longint'(ANG_T4)
        - longint'(ANG_T5) + longint'(ANG_T6) - longint'(ANG_T7) + longint'(ANG_T8)
        - longint'(ANG_T9) + longint'(ANG_T10);
    localparam longint COS_CL = (COS_C < 0) ? 0 :
                                ((COS_C > ONE_Q30) ? longint'(ONE_Q30) : COS_C);
    localparam logic [30:0] COS_SQ = 31'((64'(COS_CL) * 64'(COS_CL)) >> 30);

    // Configuration register indexes
    localparam logic [2:0] CFG_CAM_POS_X  = 3'd0;
    localparam logic [2:0] CFG_CAM_POS_Y  = 3'd1;
    localparam logic [2:0] CFG_CAM_POS_Z  = 3'd2;
    localparam logic [2:0] CFG_CAM_QUAT_W = 3'd3;
    localparam logic [2:0] CFG_CAM_QUAT_X = 3'd4;
    localparam logic [2:0] CFG_CAM_QUAT_Y = 3'd5;
    localparam logic [2:0] CFG_CAM_QUAT_Z = 3'd6;
    localparam logic [2:0] CFG_EDGE_MARGIN = 3'd7;

    localparam logic [31:0] QUAT_W_RESET = 32'h4000_0000;
    localparam logic [24:0] MARGIN_RESET = 25'd1310720;

    typedef struct packed {
        logic signed [31:0] feat_x;
        logic signed [31:0] feat_y;
        logic signed [31:0] feat_z;
        logic signed [31:0] orig_pos_x;
        logic signed [31:0] orig_pos_y;
        logic signed [31:0] orig_pos_z;
        logic signed [31:0] img_u;
        logic signed [31:0] img_v;
    } t_in;

    typedef struct packed {
        logic left_right_fail;
        logic up_down_fail;
        logic behind_fail;
        logic distance_fail;
        logic angle_fail;
        logic visible;
    } t_out;

    // Third row of the inverse rotation, Q4.27
    typedef struct packed {
        logic signed [30:0] c0;
        logic signed [30:0] c1;
        logic signed [30:0] c2;
    } t_coef;

    // Vector stage results handed to the compare stages
    typedef struct packed {
        logic               lr;
        logic               ud;
        logic [65:0]        h2;
        logic [65:0]        o2;
        logic signed [66:0] dot;
        logic signed [63:0] dp0;
        logic signed [63:0] dp1;
        logic signed [63:0] dp2;
    } t_s3;

endpackage

`default_nettype wire

>>> rtl/feature_visibility_test.sv
// Top level of the feature visibility test: configuration registers, input stage,
// pipeline control. Depends on fvt_pkg, fvt_coef, fvt_vec, fvt_cmp and fvt_obuf.
//
//   channel   direction  handshake                   payload
//   -------   ---------  --------------------------  -------------------------
//   in        to block   i_in_valid / o_in_stall     i_in_data  (fvt_pkg::t_in)
//   out       from block o_out_valid / i_out_stall   o_out_data (fvt_pkg::t_out)
//   cfg       to block   i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// One transaction is accepted per cycle while o_in_stall is low; each result passes
// through the input register, seven compute stages and the output buffer in turn.
// The whole pipeline advances together while the two-entry output buffer has room;
// o_in_stall comes straight from the buffer fill level, so a stalled result never
// blocks input until both entries are taken.
// Reset (i_rst_n low, synchronous) empties the pipeline and the buffer and loads
// the default pose (origin, identity rotation) and a 20 pixel margin.
// Quaternion writes reach the depth stage through the configuration and fvt_coef registers.
`default_nettype none

module feature_visibility_test (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire fvt_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output fvt_pkg::t_out       o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [31:0]    i_cfg_data
);

    // Current pose and margin
    logic [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic [31:0] r_quat_w, r_quat_x, r_quat_y, r_quat_z;
    logic [24:0] r_margin;

    logic adv;
    logic obuf_full;

    // Input register
    logic          r_v0;
    fvt_pkg::t_in  r_in0;

    fvt_pkg::t_coef coef;
    fvt_pkg::t_s3   s3;
    logic           v3;
    logic           v7;
    fvt_pkg::t_out  res;

    // Take configuration writes; every index maps to a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x  <= '0;
            r_cam_y  <= '0;
            r_cam_z  <= '0;
            r_quat_w <= fvt_pkg::QUAT_W_RESET;
            r_quat_x <= '0;
            r_quat_y <= '0;
            r_quat_z <= '0;
            r_margin <= fvt_pkg::MARGIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fvt_pkg::CFG_CAM_POS_X:   r_cam_x  <= i_cfg_data;
                fvt_pkg::CFG_CAM_POS_Y:   r_cam_y  <= i_cfg_data;
                fvt_pkg::CFG_CAM_POS_Z:   r_cam_z  <= i_cfg_data;
                fvt_pkg::CFG_CAM_QUAT_W:  r_quat_w <= i_cfg_data;
                fvt_pkg::CFG_CAM_QUAT_X:  r_quat_x <= i_cfg_data;
                fvt_pkg::CFG_CAM_QUAT_Y:  r_quat_y <= i_cfg_data;
                fvt_pkg::CFG_CAM_QUAT_Z:  r_quat_z <= i_cfg_data;
                fvt_pkg::CFG_EDGE_MARGIN: r_margin <= i_cfg_data[24:0];
                default:                  r_margin <= r_margin;
            endcase
        end
    end

    // Advance every stage together while the output buffer can take a result
    assign adv        = !obuf_full;
    assign o_in_stall = obuf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_in_valid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in0 <= i_in_data;
        end
    end

    fvt_coef u_coef (
        .i_clk  (i_clk),
        .i_qw   (r_quat_w),
        .i_qx   (r_quat_x),
        .i_qy   (r_quat_y),
        .i_qz   (r_quat_z),
        .o_coef (coef)
    );

    fvt_vec u_vec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (r_v0),
        .i_data   (r_in0),
        .i_cam_x  (r_cam_x),
        .i_cam_y  (r_cam_y),
        .i_cam_z  (r_cam_z),
        .i_margin (r_margin),
        .i_coef   (coef),
        .o_valid  (v3),
        .o_s3     (s3)
    );

    fvt_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (v3),
        .i_s3    (s3),
        .o_valid (v7),
        .o_res   (res)
    );

    fvt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (v7 && adv),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_full  (obuf_full)
    );

endmodule

`default_nettype wire

>>> rtl/fvt_coef.sv
// Depth row coefficients from the current orientation quaternion.
// Two register stages, free running on the configuration registers; uses fvt_pkg.
`default_nettype none

module fvt_coef (
    input  wire logic          i_clk,
    input  wire logic [31:0]   i_qw,
    input  wire logic [31:0]   i_qx,
    input  wire logic [31:0]   i_qy,
    input  wire logic [31:0]   i_qz,
    output fvt_pkg::t_coef     o_coef
);

    localparam logic signed [31:0] Q_POS = 32'sd1073741824;
    localparam logic signed [31:0] Q_NEG = -32'sd1073741824;

    function automatic logic signed [31:0] sat_q(input logic [31:0] raw);
        logic signed [31:0] v;
        v = raw;
        if (v > Q_POS) begin
            return Q_POS;
        end else if (v < Q_NEG) begin
            return Q_NEG;
        end
        return v;
    endfunction

    logic signed [31:0] qw, qx, qy, qz;
    logic signed [63:0] p_xz, p_wy, p_yz, p_wx, p_xx, p_yy;
    logic signed [61:0] r_xz, r_wy, r_yz, r_wx, r_xx, r_yy;
    logic [63:0] k0, k1, k2;
    fvt_pkg::t_coef r_coef;

    always_comb begin
        qw = sat_q(i_qw);
        qx = sat_q(i_qx);
        qy = sat_q(i_qy);
        qz = sat_q(i_qz);
        p_xz = qx * qz;
        p_wy = qw * qy;
        p_yz = qy * qz;
        p_wx = qw * qx;
        p_xx = qx * qx;
        p_yy = qy * qy;
    end

    always_ff @(posedge i_clk) begin
        r_xz <= p_xz[61:0];
        r_wy <= p_wy[61:0];
        r_yz <= p_yz[61:0];
        r_wx <= p_wx[61:0];
        r_xx <= p_xx[61:0];
        r_yy <= p_yy[61:0];
    end

    // Floor of k / 2^33 is the top bits of the two's complement value
    always_comb begin
        k0 = ({{2{r_xz[61]}}, r_xz} + {{2{r_wy[61]}}, r_wy}) << 1;
        k1 = ({{2{r_yz[61]}}, r_yz} - {{2{r_wx[61]}}, r_wx}) << 1;
        k2 = 64'h1000_0000_0000_0000 - (({2'b00, r_xx} + {2'b00, r_yy}) << 1);
    end

    always_ff @(posedge i_clk) begin
        r_coef.c0 <= k0[63:33];
        r_coef.c1 <= k1[63:33];
        r_coef.c2 <= k2[63:33];
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

>>> rtl/fvt_vec.sv
// Vector stages: differences, image edge tests, products and their sums.
// Three register stages under a shared advance enable; uses fvt_pkg.
`default_nettype none

module fvt_vec (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic            i_valid,
    input  wire fvt_pkg::t_in    i_data,
    input  wire logic [31:0]     i_cam_x,
    input  wire logic [31:0]     i_cam_y,
    input  wire logic [31:0]     i_cam_z,
    input  wire logic [24:0]     i_margin,
    input  wire fvt_pkg::t_coef  i_coef,
    output logic                 o_valid,
    output fvt_pkg::t_s3         o_s3
);

    function automatic logic signed [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] ea, eb;
        ea = {a[31], a};
        eb = {b[31], b};
        return ea - eb;
    endfunction

    logic r_v1, r_v2, r_v3;

    // Stage 1
    logic signed [32:0] n_h1 [3];
    logic signed [32:0] n_o1 [3];
    logic signed [33:0] u34, v34, m34;
    logic n_lr1, n_ud1;
    logic signed [32:0] r_h1 [3];
    logic signed [32:0] r_o1 [3];
    logic r_lr1, r_ud1;

    // Stage 2
    logic signed [65:0] n_hh2 [3];
    logic signed [65:0] n_oo2 [3];
    logic signed [65:0] n_ho2 [3];
    logic [64:0]        r_hh2 [3];
    logic [64:0]        r_oo2 [3];
    logic signed [65:0] r_ho2 [3];
    logic signed [32:0] r_h2 [3];
    logic r_lr2, r_ud2;

    // Stage 3
    fvt_pkg::t_s3 n_s3, r_s3;

    always_comb begin
        n_h1[0] = diff33(i_data.feat_x, i_cam_x);
        n_h1[1] = diff33(i_data.feat_y, i_cam_y);
        n_h1[2] = diff33(i_data.feat_z, i_cam_z);
        n_o1[0] = diff33(i_data.feat_x, i_data.orig_pos_x);
        n_o1[1] = diff33(i_data.feat_y, i_data.orig_pos_y);
        n_o1[2] = diff33(i_data.feat_z, i_data.orig_pos_z);
        u34 = {{2{i_data.img_u[31]}}, i_data.img_u};
        v34 = {{2{i_data.img_v[31]}}, i_data.img_v};
        m34 = {9'd0, i_margin};
        n_lr1 = (u34 < m34) || (u34 > fvt_pkg::U_LIMIT - m34);
        n_ud1 = (v34 < m34) || (v34 > fvt_pkg::V_LIMIT - m34);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_hh2[i] = r_h1[i] * r_h1[i];
            n_oo2[i] = r_o1[i] * r_o1[i];
            n_ho2[i] = r_h1[i] * r_o1[i];
        end
    end

    always_comb begin
        n_s3.lr  = r_lr2;
        n_s3.ud  = r_ud2;
        n_s3.h2  = 66'(r_hh2[0]) + 66'(r_hh2[1]) + 66'(r_hh2[2]);
        n_s3.o2  = 66'(r_oo2[0]) + 66'(r_oo2[1]) + 66'(r_oo2[2]);
        n_s3.dot = r_ho2[0] + r_ho2[1] + r_ho2[2];
        n_s3.dp0 = i_coef.c0 * r_h2[0];
        n_s3.dp1 = i_coef.c1 * r_h2[1];
        n_s3.dp2 = i_coef.c2 * r_h2[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_h1[i]  <= n_h1[i];
                r_o1[i]  <= n_o1[i];
                r_hh2[i] <= n_hh2[i][64:0];
                r_oo2[i] <= n_oo2[i][64:0];
                r_ho2[i] <= n_ho2[i];
                r_h2[i]  <= r_h1[i];
            end
            r_lr1 <= n_lr1;
            r_ud1 <= n_ud1;
            r_lr2 <= r_lr1;
            r_ud2 <= r_ud1;
            r_s3  <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_s3    = r_s3;

endmodule

`default_nettype wire

>>> rtl/fvt_cmp.sv
// Compare stages: depth sign, length ratio, and the wide angle products.
// Four register stages under a shared advance enable; uses fvt_pkg.
`default_nettype none

module fvt_cmp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire fvt_pkg::t_s3  i_s3,
    output logic               o_valid,
    output fvt_pkg::t_out      o_res
);

    typedef struct packed {
        logic lr;
        logic ud;
        logic behind;
        logic ratio_fail;
        logic ang_en;
        logic dot_pos;
    } t_flags;

    logic r_v4, r_v5, r_v6, r_v7;

    // Stage 4
    logic signed [65:0] depth;
    logic [72:0] h2r, o2r;
    logic [32:0] a1, a0, b1, b0, c1, c0;
    t_flags n_f4, r_f4, r_f5, r_f6, r_f7;
    logic [65:0] r_pa11, r_pa10, r_pa00;
    logic [65:0] r_pb11, r_pb10, r_pb01, r_pb00;

    // Stage 5
    logic [131:0] n_dsq5, n_p5, r_dsq5, r_p5;

    // Stage 6
    logic [63:0] n_pc6 [4];
    logic [63:0] r_pc6 [4];
    logic [131:0] r_dsq6;

    // Stage 7
    logic [161:0] n_rhs7, r_rhs7;
    logic [131:0] r_dsq7;
    logic [161:0] lhs;

    always_comb begin
        depth = i_s3.dp0 + i_s3.dp1 + i_s3.dp2;
        h2r = 73'(i_s3.h2) * 73'(fvt_pkg::RATIO_SQ);
        o2r = 73'(i_s3.o2) * 73'(fvt_pkg::RATIO_SQ);
        n_f4.lr         = i_s3.lr;
        n_f4.ud         = i_s3.ud;
        n_f4.behind     = depth[65] || (depth == '0);
        n_f4.ratio_fail = ({7'd0, i_s3.h2} > o2r) || (h2r < {7'd0, i_s3.o2});
        n_f4.ang_en     = (i_s3.h2 != '0) && (i_s3.o2 != '0);
        n_f4.dot_pos    = !i_s3.dot[66] && (i_s3.dot != '0);
        // Split the low 66 bits of each operand into two 33-bit halves
        a1 = i_s3.dot[65:33];
        a0 = i_s3.dot[32:0];
        b1 = i_s3.h2[65:33];
        b0 = i_s3.h2[32:0];
        c1 = i_s3.o2[65:33];
        c0 = i_s3.o2[32:0];
    end

    always_comb begin
        n_dsq5 = {r_pa11, 66'd0} + 132'({r_pa10, 34'd0}) + 132'(r_pa00);
        n_p5   = {r_pb11, 66'd0} + 132'({67'(r_pb10) + 67'(r_pb01), 33'd0})
               + 132'(r_pb00);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_pc6[k] = r_p5[33*k +: 33] * fvt_pkg::COS_SQ;
        end
    end

    always_comb begin
        n_rhs7 = 162'(r_pc6[0]) + 162'({r_pc6[1], 33'd0}) + 162'({r_pc6[2], 66'd0})
               + 162'({r_pc6[3], 99'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_adv) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_f4   <= n_f4;
            r_pa11 <= a1 * a1;
            r_pa10 <= a1 * a0;
            r_pa00 <= a0 * a0;
            r_pb11 <= b1 * c1;
            r_pb10 <= b1 * c0;
            r_pb01 <= b0 * c1;
            r_pb00 <= b0 * c0;
            r_f5   <= r_f4;
            r_dsq5 <= n_dsq5;
            r_p5   <= n_p5;
            r_f6   <= r_f5;
            r_dsq6 <= r_dsq5;
            for (int k = 0; k < 4; k++) begin
                r_pc6[k] <= n_pc6[k];
            end
            r_f7   <= r_f6;
            r_dsq7 <= r_dsq6;
            r_rhs7 <= n_rhs7;
        end
    end

    // Fail when the view direction turned past the limit: dot^2 * 2^30 < C |h|^2 |o|^2
    always_comb begin
        lhs = {r_dsq7, 30'd0};
        o_res.left_right_fail = r_f7.lr;
        o_res.up_down_fail    = r_f7.ud;
        o_res.behind_fail     = r_f7.behind;
        o_res.distance_fail   = r_f7.ratio_fail;
        o_res.angle_fail      = r_f7.ang_en && (!r_f7.dot_pos || (lhs < r_rhs7));
        o_res.visible         = !(r_f7.lr || r_f7.ud || r_f7.behind || r_f7.ratio_fail
                                  || o_res.angle_fail);
    end

    assign o_valid = r_v7;

endmodule

`default_nettype wire

>>> rtl/fvt_obuf.sv
// Two-entry output buffer; its fill level is the pipeline's advance condition.
// Uses fvt_pkg for the result type.
`default_nettype none

module fvt_obuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire fvt_pkg::t_out  i_data,
    input  wire logic           i_stall,
    output logic                o_valid,
    output fvt_pkg::t_out       o_data,
    output logic                o_full
);

    fvt_pkg::t_out r_mem [2];
    logic [1:0] r_count, n_count;
    logic r_wr_ptr, r_rd_ptr;
    logic pop;

    assign pop = (r_count != 2'd0) && !i_stall;

    always_comb begin
        n_count = r_count + 2'(i_wr) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);

endmodule

`default_nettype wire
